// ===== hdl/osrb_pkg.sv =====
// Shared types, constants and command codes for the overwriting sample ring buffer.
`timescale 1ns / 1ps

package osrb_pkg;

   // Field widths fixed by the block's transfer format
   localparam int unsigned CMD_W       = 3;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned CNT_FIELD_W = 13;
   localparam int unsigned OFFSET_W    = 12;
   localparam int unsigned TALLY_W     = 16;

   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   // Defaults for the top-level parameters
   localparam int unsigned DEPTH_DEFAULT       = 4096;
   localparam int unsigned SAMPLE_BITS_DEFAULT = 16;

   // Register file
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY_ADDR = 2'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_DISCARD = 3'd1,
      CMD_FILL    = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_READ    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_FILL
   } seq_state_type;

   typedef struct packed {
      logic accept;
      logic ready;
      logic read_phase;
      logic fill_phase;
      logic fill_done;
   } osrb_ctrl_type;

endpackage

// ===== hdl/osrb_if.sv =====
// Request and response channel interfaces of the sample ring buffer.
`timescale 1ns / 1ps

interface osrb_req_if import osrb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   logic                       batch_first;
   logic [CNT_FIELD_W-1:0]     discard_count;
   logic [OFFSET_W-1:0]        read_offset;

   modport source (output valid, command, left_in, right_in, batch_first,
                   discard_count, read_offset, input ready);
   modport sink   (input valid, command, left_in, right_in, batch_first,
                   discard_count, read_offset, output ready);
endinterface

interface osrb_rsp_if import osrb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       read_valid;
   logic [CNT_FIELD_W-1:0]     held_count;
   logic [CNT_FIELD_W-1:0]     contiguous_count;
   logic [TALLY_W-1:0]         dropped_count;

   modport source (output valid, left_out, right_out, read_valid, held_count,
                   contiguous_count, dropped_count, input ready);
   modport sink   (input valid, left_out, right_out, read_valid, held_count,
                   contiguous_count, dropped_count, output ready);
endinterface

// ===== hdl/osrb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module osrb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/osrb_seq.sv =====
// Command sequencer: handshake interlock, read wait and fill address walk.
`timescale 1ns / 1ps

module osrb_seq import osrb_pkg::*; #(
   parameter int unsigned CW = 13,
   parameter int unsigned IW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_free,
   input  logic          start_read,
   input  logic          start_fill,
   input  logic [CW-1:0] capacity,
   output osrb_ctrl_type ctrl,
   output logic [IW-1:0] fill_addr
);

   seq_state_type state_ff, state_in;
   logic [IW-1:0] fill_addr_ff, fill_addr_in;
   logic          fill_last;

   assign fill_last = (CW'(fill_addr_ff) == (capacity - CW'(1)));

   // outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         SEQ_IDLE: begin
            ctrl.ready  = rsp_free;
            ctrl.accept = rsp_free && req_valid;
         end
         SEQ_READ: begin
            ctrl.read_phase = 1'b1;
         end
         SEQ_FILL: begin
            ctrl.fill_phase = 1'b1;
            ctrl.fill_done  = fill_last;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (ctrl.accept && start_read) begin
               state_in = SEQ_READ;
            end else if (ctrl.accept && start_fill) begin
               state_in = SEQ_FILL;
            end
         end
         SEQ_READ: begin
            state_in = SEQ_IDLE;
         end
         SEQ_FILL: begin
            if (fill_last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      fill_addr_in = fill_addr_ff;
      if (ctrl.accept && start_fill) begin
         fill_addr_in = '0;
      end else if (ctrl.fill_phase) begin
         fill_addr_in = fill_addr_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         fill_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
      end
   end

   assign fill_addr = fill_addr_ff;

endmodule

// ===== hdl/overwriting_sample_ring_buffer_core.sv =====
// Top level of the overwriting stereo sample ring buffer.
//
//  Channel   Direction  Handshake              Carries
//  req_bus   in         valid/ready            command, sample, batch flag, count, offset
//  rsp_bus   out        valid/ready            read sample, read_valid, status counts
//  APB       in/out     psel/penable, pready=1 capacity register at byte address 0
//
// Push, discard, clear and unknown codes: the result is registered at the accepting
// edge. Read within the held samples: the registered read port of the sample RAM,
// then the result register; a read past the held samples answers at the accepting edge.
// Fill: one RAM write per cycle from a single write port.
// Reset: synchronous; capacity goes to DEPTH, buffer empty, tally zero. RAM contents
// are left as they are (no clearing pass); a slot is only read after it was written.
// Stalls: the result register holds while rsp_bus.ready is low; a new request is
// taken in the same cycle the pending result is transferred.
`timescale 1ns / 1ps

module overwriting_sample_ring_buffer_core import osrb_pkg::*; #(
   parameter int unsigned DEPTH       = DEPTH_DEFAULT,
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   osrb_req_if.sink              req_bus,
   osrb_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Widths: CW holds a count up to DEPTH, IW a slot index, XW is the compare width
   // shared with the 13-bit transfer fields, SW one bit more for index sums.
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned XW = (CW > CNT_FIELD_W) ? CW : CNT_FIELD_W;
   localparam int unsigned SW = XW + 1;
   localparam int unsigned WW = 2 * SAMPLE_BITS;

   // ---------------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------------
   // Sum of an index and a step below capacity wraps with one compare-subtract.
   function automatic logic [IW-1:0] wrap_sum(input logic [SW-1:0] s,
                                              input logic [CW-1:0] cap);
      logic [SW-1:0] c;
      c = SW'(cap);
      if (s >= c) begin
         wrap_sum = IW'(s - c);
      end else begin
         wrap_sum = IW'(s);
      end
   endfunction

   // Run from the oldest slot to the end of the used store, limited to the fill level.
   function automatic logic [CW-1:0] run_len(input logic [CW-1:0] fill,
                                             input logic [IW-1:0] oldest,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] d;
      d = cap - CW'(oldest);
      run_len = (fill < d) ? fill : d;
   endfunction

   // ---------------------------------------------------------------------------
   // Buffer state
   // ---------------------------------------------------------------------------
   logic [CW-1:0]      cap_ff, cap_in;
   logic [IW-1:0]      oldest_ff, oldest_in;
   logic [IW-1:0]      wr_ff, wr_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    left_ff, right_ff;
   logic                   rvalid_ff;
   logic [CNT_FIELD_W-1:0] held_ff, run_ff;
   logic [TALLY_W-1:0]     drop_ff;

   logic [WW-1:0] fill_word_ff;

   osrb_ctrl_type ctrl;
   logic [IW-1:0] fill_addr;
   logic          rsp_free;

   logic                 cfg_wr;
   logic [XW-1:0]        cfg_val;
   logic [CW-1:0]        cfg_cap;

   logic                 is_push, is_fill, is_read;
   logic                 rd_in_range;
   logic                 start_read, start_fill;
   logic [WW-1:0]        push_word;
   logic [31:0]          left_ext, right_ext;
   logic [TALLY_W-1:0]   tally_base;
   logic [IW-1:0]        wr_step;
   logic [SW-1:0]        fill_inc;
   logic [IW-1:0]        rd_idx;

   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [WW-1:0]        ram_wr_data;
   logic                 ram_rd_en;
   logic [WW-1:0]        ram_rd_data;
   logic [31:0]          rd_left_z, rd_right_z;

   logic                 load_now, load_any;
   logic [CW-1:0]        run_next, run_cur;

   // ---------------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr == CSR_CAPACITY_ADDR);
   assign prdata = (paddr == CSR_CAPACITY_ADDR) ? CSR_DATA_W'(cap_ff) : '0;

   // capacity is clamped into 1..DEPTH
   assign cfg_val = XW'(pwdata[CNT_FIELD_W-1:0]);
   always_comb begin
      if (cfg_val == '0) begin
         cfg_cap = CW'(1);
      end else if (cfg_val > XW'(DEPTH)) begin
         cfg_cap = CW'(DEPTH);
      end else begin
         cfg_cap = CW'(cfg_val);
      end
   end

   // ---------------------------------------------------------------------------
   // Command decode
   // ---------------------------------------------------------------------------
   assign is_push    = (req_bus.command == CMD_PUSH);
   assign is_fill    = (req_bus.command == CMD_FILL);
   assign is_read    = (req_bus.command == CMD_READ);

   assign rd_in_range = (XW'(req_bus.read_offset) < XW'(fill_ff));
   assign start_read  = is_read && rd_in_range;
   assign start_fill  = is_fill;

   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = ctrl.ready;

   // Samples are sign-extended from 16 bits, then cut to the channel width.
   assign left_ext  = {{(32 - SAMPLE_W){req_bus.left_in[SAMPLE_W-1]}}, req_bus.left_in};
   assign right_ext = {{(32 - SAMPLE_W){req_bus.right_in[SAMPLE_W-1]}}, req_bus.right_in};
   assign push_word = {left_ext[SAMPLE_BITS-1:0], right_ext[SAMPLE_BITS-1:0]};

   assign tally_base = req_bus.batch_first ? '0 : tally_ff;
   assign wr_step    = wrap_sum(SW'(wr_ff) + SW'(1), cap_ff);
   assign fill_inc   = SW'(fill_ff) + SW'(1);
   assign rd_idx     = wrap_sum(SW'(oldest_ff) + SW'(req_bus.read_offset), cap_ff);

   // ---------------------------------------------------------------------------
   // State update
   // ---------------------------------------------------------------------------
   always_comb begin
      cap_in    = cap_ff;
      oldest_in = oldest_ff;
      wr_in     = wr_ff;
      fill_in   = fill_ff;
      tally_in  = tally_ff;
      if (cfg_wr) begin
         // new capacity empties the buffer and zeroes the tally
         cap_in    = cfg_cap;
         oldest_in = '0;
         wr_in     = '0;
         fill_in   = '0;
         tally_in  = '0;
      end else if (ctrl.accept) begin
         case (req_bus.command)
            CMD_PUSH: begin
               wr_in    = wr_step;
               tally_in = tally_base;
               if (fill_inc > SW'(cap_ff)) begin
                  // full: oldest sample overwritten, tally saturates
                  if (tally_base != TALLY_MAX) begin
                     tally_in = tally_base + TALLY_W'(1);
                  end
                  fill_in   = cap_ff;
                  oldest_in = wr_step;
               end else begin
                  fill_in = CW'(fill_inc);
               end
            end
            CMD_DISCARD: begin
               if (XW'(req_bus.discard_count) >= XW'(fill_ff)) begin
                  oldest_in = '0;
                  wr_in     = '0;
                  fill_in   = '0;
               end else begin
                  oldest_in = wrap_sum(SW'(oldest_ff) + SW'(req_bus.discard_count), cap_ff);
                  fill_in   = fill_ff - CW'(req_bus.discard_count);
               end
            end
            CMD_FILL: begin
               // state settles now; the RAM walk follows in the sequencer
               tally_in  = '0;
               fill_in   = cap_ff;
               oldest_in = '0;
               wr_in     = '0;
            end
            CMD_CLEAR: begin
               oldest_in = '0;
               wr_in     = '0;
               fill_in   = '0;
            end
            default: begin
               // read and unknown codes leave the state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CW'(DEPTH);
         oldest_ff <= '0;
         wr_ff     <= '0;
         fill_ff   <= '0;
         tally_ff  <= '0;
      end else begin
         cap_ff    <= cap_in;
         oldest_ff <= oldest_in;
         wr_ff     <= wr_in;
         fill_ff   <= fill_in;
         tally_ff  <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept && start_fill) begin
         fill_word_ff <= push_word;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer and sample RAM
   // ---------------------------------------------------------------------------
   osrb_seq #(
      .CW (CW),
      .IW (IW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .rsp_free   (rsp_free),
      .start_read (start_read),
      .start_fill (start_fill),
      .capacity   (cap_ff),
      .ctrl       (ctrl),
      .fill_addr  (fill_addr)
   );

   // one write port shared by push and the fill walk
   assign ram_wr_en   = (ctrl.accept && is_push) || ctrl.fill_phase;
   assign ram_wr_addr = ctrl.fill_phase ? fill_addr : wr_ff;
   assign ram_wr_data = ctrl.fill_phase ? fill_word_ff : push_word;
   assign ram_rd_en   = ctrl.accept && start_read;

   osrb_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   // channel bits are zero-extended, then cut to the 16-bit result field
   assign rd_left_z  = 32'(ram_rd_data[WW-1:SAMPLE_BITS]);
   assign rd_right_z = 32'(ram_rd_data[SAMPLE_BITS-1:0]);

   // ---------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------
   // Immediate commands answer from the updated state at the accepting edge;
   // in-range read and fill answer later from the registered state.
   assign load_now = ctrl.accept && !start_read && !start_fill;
   assign load_any = load_now || ctrl.read_phase || ctrl.fill_done;
   assign run_next = run_len(fill_in, oldest_in, cap_in);
   assign run_cur  = run_len(fill_ff, oldest_ff, cap_ff);

   assign rsp_valid_in = load_any || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now) begin
         left_ff   <= '0;
         right_ff  <= '0;
         rvalid_ff <= 1'b0;
         held_ff   <= CNT_FIELD_W'(fill_in);
         run_ff    <= CNT_FIELD_W'(run_next);
         drop_ff   <= tally_in;
      end else if (ctrl.read_phase || ctrl.fill_done) begin
         left_ff   <= ctrl.read_phase ? rd_left_z[SAMPLE_W-1:0] : '0;
         right_ff  <= ctrl.read_phase ? rd_right_z[SAMPLE_W-1:0] : '0;
         rvalid_ff <= ctrl.read_phase;
         held_ff   <= CNT_FIELD_W'(fill_ff);
         run_ff    <= CNT_FIELD_W'(run_cur);
         drop_ff   <= tally_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.left_out         = $signed(left_ff);
   assign rsp_bus.right_out        = $signed(right_ff);
   assign rsp_bus.read_valid       = rvalid_ff;
   assign rsp_bus.held_count       = held_ff;
   assign rsp_bus.contiguous_count = run_ff;
   assign rsp_bus.dropped_count    = drop_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_fill_le_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill level above capacity");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(oldest_ff) < cap_ff) && (CW'(wr_ff) < cap_ff))
      else $error("ring index outside capacity");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      load_any |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result loaded over an untaken transfer");

   a_full_push_wraps: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && is_push && (fill_ff == cap_ff)) |=> (oldest_ff == wr_ff))
      else $error("full push did not move the oldest slot to the write slot");
`endif

endmodule

// ===== tb/sv/osrb_ring_checker.sv =====
// Checker for the sample ring buffer: mirrors the buffer state and compares every response.
`timescale 1ns / 1ps

module osrb_ring_checker import osrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   osrb_req_if                   req_mon,
   osrb_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int unsigned           pending,
   output int unsigned           fail_count
);

   localparam int unsigned SLOTS = DEPTH_DEFAULT;

   typedef struct packed {
      logic [SAMPLE_W-1:0]    left_out;
      logic [SAMPLE_W-1:0]    right_out;
      logic                   read_valid;
      logic [CNT_FIELD_W-1:0] held_count;
      logic [CNT_FIELD_W-1:0] contiguous_count;
      logic [TALLY_W-1:0]     dropped_count;
   } ring_status_type;

   logic [SAMPLE_W-1:0] left_slot  [SLOTS];
   logic [SAMPLE_W-1:0] right_slot [SLOTS];
   int unsigned capacity = SLOTS;
   int unsigned oldest   = 0;
   int unsigned wr_pos   = 0;
   int unsigned level    = 0;
   int unsigned tally    = 0;
   int unsigned errors   = 0;

   ring_status_type awaited_status [$];

   function automatic int unsigned ring_advance(input int unsigned a, input int unsigned b);
      int unsigned r;
      r = a + b;
      if (r >= capacity) begin
         r -= capacity;
      end
      return r;
   endfunction

   function automatic void empty_ring();
      oldest = 0;
      wr_pos = 0;
      level  = 0;
   endfunction

   // Applies one command to the mirrored state and returns the status it answers with.
   function automatic ring_status_type predict_status(
      input logic [CMD_W-1:0]       command,
      input logic [SAMPLE_W-1:0]    left_in,
      input logic [SAMPLE_W-1:0]    right_in,
      input logic                   batch_first,
      input logic [CNT_FIELD_W-1:0] discard_count,
      input logic [OFFSET_W-1:0]    read_offset
   );
      ring_status_type st;
      int unsigned     idx;
      int unsigned     run;
      st = '0;
      case (command)
         CMD_PUSH: begin
            if (batch_first) begin
               tally = 0;
            end
            left_slot[wr_pos]  = left_in;
            right_slot[wr_pos] = right_in;
            wr_pos = ring_advance(wr_pos, 1);
            level++;
            if (level > capacity) begin
               if (tally < TALLY_MAX) begin
                  tally++;
               end
               level  = capacity;
               oldest = wr_pos;
            end
         end
         CMD_DISCARD: begin
            if (discard_count >= level) begin
               empty_ring();
            end else begin
               oldest = ring_advance(oldest, discard_count);
               level -= discard_count;
            end
         end
         CMD_FILL: begin
            for (int i = 0; i < SLOTS; i++) begin
               left_slot[i]  = left_in;
               right_slot[i] = right_in;
            end
            tally  = 0;
            level  = capacity;
            oldest = 0;
            wr_pos = 0;
         end
         CMD_CLEAR: begin
            empty_ring();
         end
         CMD_READ: begin
            if (read_offset < level) begin
               idx = ring_advance(oldest, read_offset) % SLOTS;
               st.left_out   = left_slot[idx];
               st.right_out  = right_slot[idx];
               st.read_valid = 1'b1;
            end
         end
         default: ;
      endcase
      run = capacity - oldest;
      if (run > level) begin
         run = level;
      end
      st.held_count       = level[CNT_FIELD_W-1:0];
      st.contiguous_count = run[CNT_FIELD_W-1:0];
      st.dropped_count    = tally[TALLY_W-1:0];
      return st;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      ring_status_type        want;
      logic [CNT_FIELD_W-1:0] cap_field;
      if (reset) begin
         capacity = SLOTS;
         empty_ring();
         tally = 0;
         awaited_status.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_CAPACITY_ADDR) begin
            cap_field = pwdata[CNT_FIELD_W-1:0];
            capacity  = (cap_field == 0) ? 1 : (cap_field > SLOTS) ? SLOTS : cap_field;
            empty_ring();
            tally = 0;
         end
         // response first, so a response cannot be matched to a request of the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_status.size() == 0) begin
               $error("response transfer with nothing outstanding");
               errors++;
            end else begin
               want = awaited_status.pop_front();
               check_field("left_out", want.left_out, rsp_mon.left_out);
               check_field("right_out", want.right_out, rsp_mon.right_out);
               check_field("read_valid", 16'(want.read_valid), 16'(rsp_mon.read_valid));
               check_field("held_count", 16'(want.held_count), 16'(rsp_mon.held_count));
               check_field("contiguous_count", 16'(want.contiguous_count),
                           16'(rsp_mon.contiguous_count));
               check_field("dropped_count", want.dropped_count, rsp_mon.dropped_count);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_status.push_back(predict_status(req_mon.command, req_mon.left_in,
                                                    req_mon.right_in, req_mon.batch_first,
                                                    req_mon.discard_count,
                                                    req_mon.read_offset));
         end
      end
      pending    <= awaited_status.size();
      fail_count <= errors;
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the ring buffer testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module testbench;
   import osrb_pkg::*;

   // Command codes the block does not define; they must leave the state alone.
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   // Idling schemes, cycled through the random phases
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   localparam int unsigned RANDOM_PHASES    = 10;
   localparam int unsigned ITEMS_PER_PHASE  = 160;
   localparam int unsigned OVERWRITE_PUSHES = 40;  // each one overwrites the single slot
   // Longest honest silence is a full-depth fill walk plus stalls.
   localparam int unsigned WATCHDOG_LIMIT  = 40000;

   typedef struct {
      logic [CMD_W-1:0]       command;
      logic [SAMPLE_W-1:0]    left_in;
      logic [SAMPLE_W-1:0]    right_in;
      logic                   batch_first;
      logic [CNT_FIELD_W-1:0] discard_count;
      logic [OFFSET_W-1:0]    read_offset;
   } ring_request_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned pending;
   int unsigned fail_count;
   int unsigned quiet_cycles = 0;
   int unsigned send_gap_pct = 0;  // chance per cycle that the sender holds off
   int unsigned stall_pct    = 0;  // chance per cycle that the receiver stalls
   int unsigned cap_now      = DEPTH_DEFAULT;

   osrb_req_if req_ch ();
   osrb_rsp_if rsp_ch ();

   overwriting_sample_ring_buffer_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   osrb_ring_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: ready is redrawn every edge, so stalls land on every phase of the work
   // (read latency, fill walk, back-to-back pushes).
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: counts edges without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic set_idling(input int scheme);
      send_gap_pct = (scheme == IDLE_SENDER) ? 67 : (scheme == IDLE_BOTH) ? 29 : 0;
      stall_pct    = (scheme == IDLE_RECEIVER) ? 67 : (scheme == IDLE_BOTH) ? 29 : 0;
   endtask

   function automatic ring_request_type order(
      input logic [CMD_W-1:0]       command,
      input logic [SAMPLE_W-1:0]    left_in,
      input logic [SAMPLE_W-1:0]    right_in,
      input logic                   batch_first,
      input logic [CNT_FIELD_W-1:0] discard_count,
      input logic [OFFSET_W-1:0]    read_offset
   );
      ring_request_type rq;
      rq.command       = command;
      rq.left_in       = left_in;
      rq.right_in      = right_in;
      rq.batch_first   = batch_first;
      rq.discard_count = discard_count;
      rq.read_offset   = read_offset;
      return rq;
   endfunction

   // Called at a rising edge; returns at the edge where the request transfer took place.
   task automatic send_request(input ring_request_type rq);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= rq.command;
      req_ch.left_in       <= rq.left_in;
      req_ch.right_in      <= rq.right_in;
      req_ch.batch_first   <= rq.batch_first;
      req_ch.discard_count <= rq.discard_count;
      req_ch.read_offset   <= rq.read_offset;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Drop valid and wait until every response is back. Every command answers, so the
   // block is idle once the checker has nothing outstanding; a few spare edges anyway.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Register write: setup, then access; the write lands on the access edge.
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] value);
      logic [CNT_FIELD_W-1:0] field;
      field   = value[CNT_FIELD_W-1:0];
      cap_now = (field == 0) ? 1 : (field > DEPTH_DEFAULT) ? DEPTH_DEFAULT : field;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_CAPACITY_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random command mix: pushes and reads dominate so the buffer fills and wraps;
   // offsets and discard counts lean towards the live range of the current capacity.
   function automatic ring_request_type random_request();
      ring_request_type rq;
      int unsigned      pick;
      int unsigned      shape;
      pick             = $urandom_range(0, 99);
      shape            = $urandom_range(0, 9);
      rq.left_in       = SAMPLE_W'($urandom);
      rq.right_in      = SAMPLE_W'($urandom);
      rq.batch_first   = ($urandom_range(0, 7) == 0);
      rq.read_offset   = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom) :
                                                       OFFSET_W'($urandom_range(0, cap_now - 1));
      rq.discard_count = (shape == 0) ? CNT_FIELD_W'(DEPTH_DEFAULT) :
                         (shape < 4)  ? CNT_FIELD_W'($urandom_range(0, DEPTH_DEFAULT)) :
                                        CNT_FIELD_W'($urandom_range(0, (cap_now + 3) / 4));
      if (pick < 45) begin
         rq.command = CMD_PUSH;
      end else if (pick < 75) begin
         rq.command = CMD_READ;
      end else if (pick < 86) begin
         rq.command = CMD_DISCARD;
      end else if (pick < 90) begin
         rq.command = CMD_CLEAR;
      end else if (pick < 94) begin
         // a fill walks the whole used store, so keep it rare at large capacities
         rq.command = (cap_now <= 64 || $urandom_range(0, 19) == 0) ? CMD_FILL : CMD_PUSH;
      end else begin
         rq.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      return rq;
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] capacity_plan [RANDOM_PHASES];
      capacity_plan = '{32'd1, 32'd0, 32'd2, 32'd3, 32'hFFFF_E005, 32'd16, 32'd8191,
                        32'd4096, 32'd0, 32'd0};
      capacity_plan[8] = $urandom_range(4, 64);
      capacity_plan[9] = $urandom_range(65, 4095);

      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.command       <= CMD_PUSH;
      req_ch.left_in       <= '0;
      req_ch.right_in      <= '0;
      req_ch.batch_first   <= 1'b0;
      req_ch.discard_count <= '0;
      req_ch.read_offset   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass at the reset capacity (full depth)
      set_idling(IDLE_NONE);
      send_request(order(CMD_READ, 16'h1234, 16'h4321, 1'b0, 13'd0, 12'd0));  // empty read
      send_request(order(CMD_PUSH, 16'h7FFF, 16'h8000, 1'b1, 13'd0, 12'd0));
      send_request(order(CMD_PUSH, 16'h8000, 16'h7FFF, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_PUSH, 16'h0000, 16'hFFFF, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd1));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd2));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd3));    // past end
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd4095));
      send_request(order(CMD_DISCARD, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_DISCARD, 16'h0000, 16'h0000, 1'b0, 13'd1, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 1'b1, 13'h1FFF, 12'hFFF));
      send_request(order(CMD_SPARE_MID, 16'h5A5A, 16'hA5A5, 1'b0, 13'd5, 12'd1));
      send_request(order(CMD_SPARE_LAST, 16'h0001, 16'h0002, 1'b1, 13'd4096, 12'd0));
      send_request(order(CMD_CLEAR, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_DISCARD, 16'h0000, 16'h0000, 1'b0, 13'd4096, 12'd0));
      send_request(order(CMD_FILL, 16'h5555, 16'hAAAA, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd4095));
      send_request(order(CMD_PUSH, 16'h0102, 16'h0304, 1'b1, 13'd0, 12'd0));    // overwrites
      send_request(order(CMD_PUSH, 16'h0506, 16'h0708, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd4095));
      send_request(order(CMD_DISCARD, 16'h0000, 16'h0000, 1'b0, 13'd4095, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_DISCARD, 16'h0000, 16'h0000, 1'b0, 13'd4096, 12'd0));  // all
      drain();

      // One slot, pushed repeatedly: every push after the first overwrites and counts,
      // then a fresh batch must restart the tally.
      write_capacity(32'd1);
      send_request(order(CMD_PUSH, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b1,
                         13'd0, 12'd0));
      repeat (OVERWRITE_PUSHES) begin
         send_request(order(CMD_PUSH, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0,
                            CNT_FIELD_W'($urandom), OFFSET_W'($urandom)));
      end
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd0));
      send_request(order(CMD_READ, 16'h0000, 16'h0000, 1'b0, 13'd0, 12'd1));
      send_request(order(CMD_PUSH, 16'h1111, 16'h2222, 1'b1, 13'd0, 12'd0));
      drain();

      // Random phases, each at its own capacity and idling scheme
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_capacity(capacity_plan[phase]);
         set_idling(phase % 4);
         if (cap_now > 64) begin
            // start full, otherwise a short phase never wraps a large store
            send_request(order(CMD_FILL, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0,
                               CNT_FIELD_W'($urandom), OFFSET_W'($urandom)));
         end
         repeat (ITEMS_PER_PHASE) begin
            send_request(random_request());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== overwriting_sample_ring_buffer_core.f =====
hdl/osrb_pkg.sv
hdl/osrb_if.sv
hdl/osrb_ram.sv
hdl/osrb_seq.sv
hdl/overwriting_sample_ring_buffer_core.sv
tb/sv/osrb_ring_checker.sv
tb/sv/testbench.sv
